// ===== sv/dde_pkg.sv =====
// ============================================================================
// Direct DFT engine package
// Shared word types, controller states, default sizes and the elaboration-time
// functions that build the twiddle table.
// ============================================================================
package dde_pkg;

    localparam int NUM_POINTS_DEF   = 1024;
    localparam int TWIDDLE_BITS_DEF = 16;
    localparam int VAL_W            = 32;
    localparam int BIN_W            = 10;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value_re;
        logic signed [VAL_W-1:0] value_im;
        logic        [BIN_W-1:0] bin_index;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_re;
        logic signed [VAL_W-1:0] result_im;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RUN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    // Cosine and sine of a Q2.30 angle in [0, pi/2), packed as {cos, sin} in Q2.30.
    function automatic logic [63:0] taylor_cs(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] ct;
        logic [63:0] st;
        logic [63:0] cpos;
        logic [63:0] cneg;
        logic [63:0] spos;
        logic [63:0] sneg;
        logic [63:0] c;
        logic [63:0] s;
        x2   = (x * x) >> 30;
        ct   = Q30_ONE;
        st   = x;
        cpos = Q30_ONE;
        cneg = 64'd0;
        spos = x;
        sneg = 64'd0;
        for (int i = 1; i <= 12; i++) begin
            ct = ((ct * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
            st = ((st * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if ((i % 2) == 1) begin
                cneg = cneg + ct;
                sneg = sneg + st;
            end else begin
                cpos = cpos + ct;
                spos = spos + st;
            end
        end
        c = (cpos > cneg) ? cpos - cneg : 64'd0;
        s = (spos > sneg) ? spos - sneg : 64'd0;
        if (c > Q30_ONE) begin
            c = Q30_ONE;
        end
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return {c[31:0], s[31:0]};
    endfunction

    // Round a Q2.30 magnitude to Q1.frac, saturate, and apply the sign.
    function automatic logic [31:0] to_twiddle(input logic [31:0] mag, input logic neg,
                                               input int frac);
        logic [63:0] r;
        logic [63:0] lim;
        r   = (64'(mag) + (64'd1 << (30 - frac - 1))) >> (30 - frac);
        lim = (64'd1 << frac) - 64'd1;
        if (r > lim) begin
            r = lim;
        end
        return neg ? -r[31:0] : r[31:0];
    endfunction

    // Quadrant reconstruction: returns {cos, sin} as 32-bit signed Q1.frac values.
    function automatic logic [63:0] twiddle_pair(input logic [63:0] cs, input logic [1:0] quad,
                                                 input int frac);
        logic [31:0] c_mag;
        logic [31:0] s_mag;
        c_mag = quad[0] ? cs[31:0] : cs[63:32];
        s_mag = quad[0] ? cs[63:32] : cs[31:0];
        return {to_twiddle(c_mag, quad[1] ^ quad[0], frac), to_twiddle(s_mag, quad[1], frac)};
    endfunction

endpackage

// ===== sv/dde_divn.sv =====
// ============================================================================
// Divider by the point count
// Floor division of an unsigned word by a power-of-two NUM_POINTS by a shift,
// with the remainder taken by a mask. The result is registered and valid in the cycle after start.
// ============================================================================
module dde_divn #(
    parameter int NUM_POINTS = dde_pkg::NUM_POINTS_DEF,
    parameter int W          = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [W-1:0]                  i_dividend,
    output logic                          o_done,
    output logic [W-1:0]                  o_quot,
    output logic [$clog2(NUM_POINTS)-1:0] o_rem
);

    localparam int SW = $clog2(NUM_POINTS);

    logic          r_done;
    logic [W-1:0]  r_quot;
    logic [SW-1:0] r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend >> SW;
            r_rem  <= i_dividend[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_done)
        else $error("divider did not finish one cycle after start");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start))
        else $error("divider done without a start");

    a_quot_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_quot == ($past(i_dividend) >> SW))
        else $error("divider quotient does not match its dividend");

endmodule

// ===== sv/direct_dft_engine.sv =====
// ============================================================================
// Direct DFT engine
// Stores NUM_POINTS complex points and returns one forward or inverse DFT bin
// per query, reading the point memory and twiddle ROM once per cycle.
// ============================================================================
// A load word is accepted every cycle while the engine is idle. A query stalls the
// input through the reduce, run, drain, divide (inverse mode only) and finish states,
// longer while an earlier result word is stalled, and its result word is valid at the
// end of that span. The point memory read port, one point per cycle, paces the run.
// Reset clears the write pointer, the mode register and all control state;
// the point memory is not cleared.
module direct_dft_engine #(
    parameter int NUM_POINTS   = dde_pkg::NUM_POINTS_DEF,
    parameter int TWIDDLE_BITS = dde_pkg::TWIDDLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dde_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dde_pkg::t_out_word o_out_word
);

    localparam int PTR_W = $clog2(NUM_POINTS);
    localparam int TW    = TWIDDLE_BITS;
    localparam int FRAC  = TWIDDLE_BITS - 1;
    localparam int XW    = dde_pkg::VAL_W;
    localparam int PW    = XW + TW;
    localparam int RPW   = PW - FRAC;
    localparam int SUM_W = RPW + 1;
    localparam int ACC_W = SUM_W + PTR_W;

    localparam logic [PTR_W-1:0] LAST = PTR_W'(NUM_POINTS - 1);
    localparam logic [PTR_W:0]   NPTS = (PTR_W + 1)'(NUM_POINTS);
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC - 1);

    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(longint'(2147483647));
    localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sd2147483648);
    localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(longint'(32767));
    localparam logic signed [ACC_W-1:0] S16_MIN = ACC_W'(-longint'(32768));

    // ------------------------------------------------------------------
    // Twiddle ROM, built at elaboration.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] w_cos_rom [NUM_POINTS];
    logic signed [TW-1:0] w_sin_rom [NUM_POINTS];

    for (genvar gi = 0; gi < NUM_POINTS; gi++) begin : g_tw
        localparam longint unsigned Q4   = 4 * gi;
        localparam longint unsigned QD   = Q4 / NUM_POINTS;
        localparam longint unsigned RM   = Q4 - QD * NUM_POINTS;
        localparam longint unsigned ANG  = (dde_pkg::HALF_PI_Q30 * RM) / NUM_POINTS;
        localparam logic [63:0]     CS   = dde_pkg::taylor_cs(64'(ANG));
        localparam logic [1:0]      QUAD = 2'(QD);
        localparam logic [63:0]     PAIR = dde_pkg::twiddle_pair(CS, QUAD, FRAC);
        assign w_cos_rom[gi] = TW'(PAIR[63:32]);
        assign w_sin_rom[gi] = TW'(PAIR[31:0]);
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [2*XW-1:0]  r_mem [NUM_POINTS];

    dde_pkg::t_state  r_state;
    dde_pkg::t_state  n_state;
    logic             r_inv;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_n;
    logic [PTR_W-1:0] r_idx;
    logic [PTR_W-1:0] r_k;
    logic             r_neg;

    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic [2*XW-1:0]         r_rd;
    logic signed [TW-1:0]    r_wr;
    logic signed [TW-1:0]    r_wi;
    logic signed [PW-1:0]    r_prr;
    logic signed [PW-1:0]    r_pii;
    logic signed [PW-1:0]    r_pri;
    logic signed [PW-1:0]    r_pir;
    logic signed [SUM_W-1:0] r_pre;
    logic signed [SUM_W-1:0] r_pim;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;

    logic               r_out_valid;
    dde_pkg::t_out_word r_out;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic w_in_acc;
    logic w_load;
    logic w_query;
    logic w_drained;
    logic w_issue;
    logic w_div_start;
    logic w_begin_run;
    logic w_load_out;

    logic             w_div_done;
    logic [ACC_W-1:0] w_div_quot;
    logic [PTR_W-1:0] w_div_rem;
    logic [ACC_W-1:0] w_dividend;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_load    = w_in_acc && (i_in_word.kind == dde_pkg::KIND_LOAD);
    assign w_query   = w_in_acc && (i_in_word.kind == dde_pkg::KIND_QUERY);
    assign w_drained = !r_v1 && !r_v2 && !r_v3;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dde_pkg::ST_IDLE: begin
                if (w_query) begin
                    n_state = dde_pkg::ST_REDUCE;
                end
            end
            dde_pkg::ST_REDUCE: begin
                if (w_div_done) begin
                    n_state = dde_pkg::ST_RUN;
                end
            end
            dde_pkg::ST_RUN: begin
                if (r_n == LAST) begin
                    n_state = dde_pkg::ST_DRAIN;
                end
            end
            dde_pkg::ST_DRAIN: begin
                if (w_drained) begin
                    n_state = r_inv ? dde_pkg::ST_DIVIDE : dde_pkg::ST_FINISH;
                end
            end
            dde_pkg::ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = dde_pkg::ST_FINISH;
                end
            end
            dde_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = dde_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dde_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_issue     = 1'b0;
        w_div_start = 1'b0;
        w_begin_run = 1'b0;
        w_load_out  = 1'b0;
        w_dividend  = r_acc_re[ACC_W-1] ? ~r_acc_re : r_acc_re;
        case (r_state)
            dde_pkg::ST_IDLE: begin
                w_div_start = w_query;
                w_dividend  = ACC_W'(i_in_word.bin_index);
            end
            dde_pkg::ST_REDUCE: begin
                w_begin_run = w_div_done;
            end
            dde_pkg::ST_RUN: begin
                w_issue = 1'b1;
            end
            dde_pkg::ST_DRAIN: begin
                w_div_start = w_drained && r_inv;
            end
            dde_pkg::ST_FINISH: begin
                w_load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
                w_issue = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_state != dde_pkg::ST_IDLE);

    dde_divn #(
        .NUM_POINTS (NUM_POINTS),
        .W          (ACC_W)
    ) u_divn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [PTR_W:0] w_idx_sum;
    assign w_idx_sum = {1'b0, r_idx} + {1'b0, r_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dde_pkg::ST_IDLE;
            r_inv       <= 1'b0;
            r_wp        <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_inv <= i_cfg_wdata;
            end
            if (w_load) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (w_begin_run) begin
                r_n   <= '0;
                r_idx <= '0;
            end else if (w_issue) begin
                r_n   <= r_n + 1'b1;
                r_idx <= (w_idx_sum >= NPTS) ? PTR_W'(w_idx_sum - NPTS) : w_idx_sum[PTR_W-1:0];
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Point memory and twiddle ROM reads
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[r_wp] <= {i_in_word.value_re, i_in_word.value_im};
        end
        r_rd <= r_mem[r_n];
    end

    always_ff @(posedge i_clk) begin
        r_wr <= w_cos_rom[r_idx];
        r_wi <= r_inv ? w_sin_rom[r_idx] : -w_sin_rom[r_idx];
    end

    // ------------------------------------------------------------------
    // Multiply, round, accumulate
    // ------------------------------------------------------------------
    logic signed [XW-1:0] w_xr;
    logic signed [XW-1:0] w_xi;
    logic signed [PW-1:0] w_rrr;
    logic signed [PW-1:0] w_rii;
    logic signed [PW-1:0] w_rri;
    logic signed [PW-1:0] w_rir;

    assign w_xr  = r_rd[2*XW-1:XW];
    assign w_xi  = r_rd[XW-1:0];
    assign w_rrr = r_prr + RND;
    assign w_rii = r_pii + RND;
    assign w_rri = r_pri + RND;
    assign w_rir = r_pir + RND;

    always_ff @(posedge i_clk) begin
        r_prr <= w_xr * r_wr;
        r_pii <= w_xi * r_wi;
        r_pri <= w_xr * r_wi;
        r_pir <= w_xi * r_wr;
        r_pre <= SUM_W'($signed(w_rrr[PW-1:FRAC])) - SUM_W'($signed(w_rii[PW-1:FRAC]));
        r_pim <= SUM_W'($signed(w_rri[PW-1:FRAC])) + SUM_W'($signed(w_rir[PW-1:FRAC]));
        if (w_begin_run) begin
            r_k      <= w_div_rem;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pre);
            r_acc_im <= r_acc_im + ACC_W'(r_pim);
        end
        if (w_div_start) begin
            r_neg <= r_acc_re[ACC_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Result formatting and output register
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] w_floor;
    logic signed [ACC_W-1:0] w_res_re;
    logic signed [ACC_W-1:0] w_res_im;

    always_comb begin
        w_floor = r_neg ? $signed(~w_div_quot) : $signed(w_div_quot);
        if (r_inv) begin
            w_res_re = (w_floor > S16_MAX) ? S16_MAX : ((w_floor < S16_MIN) ? S16_MIN : w_floor);
            w_res_im = '0;
        end else begin
            w_res_re = (r_acc_re > S32_MAX) ? S32_MAX :
                       ((r_acc_re < S32_MIN) ? S32_MIN : r_acc_re);
            w_res_im = (r_acc_im > S32_MAX) ? S32_MAX :
                       ((r_acc_im < S32_MIN) ? S32_MIN : r_acc_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.result_re <= w_res_re[XW-1:0];
            r_out.result_im <= w_res_im[XW-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pipe_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state) == dde_pkg::ST_RUN)
        else $error("memory read outside a bin sweep");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == dde_pkg::ST_FINISH)
        else $error("result word appeared without a finished query");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> r_state == dde_pkg::ST_REDUCE)
        else $error("accepted query did not start");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_wp == (($past(r_wp) == LAST) ? '0 : $past(r_wp) + 1'b1))
        else $error("write pointer did not advance on a load");

    a_drain_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dde_pkg::ST_FINISH |-> w_drained)
        else $error("result formed with products still in flight");

endmodule
